>>> sv/tapb_pkg.sv
// ----------------------------------------------------------------------------
// tapb_pkg
// Types, constants and helper functions shared by the tinted alpha blend
// pipeline.
// ----------------------------------------------------------------------------
package tapb_pkg;

	localparam int PIX_W  = 32;
	localparam int CH_W   = 8;
	localparam int OUT_W  = 24;
	localparam int WGT_W  = CH_W + 1;
	localparam int PROD_W = 2 * CH_W;

	localparam logic [PIX_W-1:0] TINT_RESET  = 32'hFFFF_FFFF;
	localparam logic [CH_W-1:0]  ALPHA_HALF  = 8'h80;
	localparam logic [WGT_W-1:0] WEIGHT_FULL = 9'h100;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [WGT_W-1:0]  weight_t;
	typedef logic [PROD_W-1:0] prod_t;

	// One ARGB pixel split into channels.
	typedef struct packed {
		chan_t a;
		chan_t r;
		chan_t g;
		chan_t b;
	} argb_t;

	// One RGB pixel, red first.
	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	// Weighted products per color channel, index 2 red, 1 green, 0 blue.
	typedef struct packed {
		logic [2:0][PROD_W-1:0] src;
		logic [2:0][PROD_W-1:0] dst;
	} prods_t;

	// Modulate one channel by one tint channel: (s * (c + 1)) >> 8.
	function automatic chan_t tint_mul(input chan_t s, input chan_t c);
		logic [PROD_W:0] p;
		p = (PROD_W+1)'(s) * ((PROD_W+1)'(c) + (PROD_W+1)'(1));
		return p[PROD_W-1:CH_W];
	endfunction

endpackage

>>> sv/tapb_tint.sv
// ----------------------------------------------------------------------------
// tapb_tint
// First pipeline stage: modulates the four source channels by the tint
// register and carries the destination color along.
// ----------------------------------------------------------------------------
module tapb_tint import tapb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	output logic             rdy_in,
	input  logic [PIX_W-1:0] src,
	input  logic [PIX_W-1:0] dst,
	input  logic [PIX_W-1:0] tint,
	output logic             vld_s1,
	input  logic             rdy_out,
	output argb_t            src_s1,
	output rgb_t             dst_s1
);

	argb_t s;
	argb_t c;

	assign s = argb_t'(src);
	assign c = argb_t'(tint);
	assign rdy_in = !vld_s1 || rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_in) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_in && vld_in) begin
			src_s1.a <= tint_mul(s.a, c.a);
			src_s1.r <= tint_mul(s.r, c.r);
			src_s1.g <= tint_mul(s.g, c.g);
			src_s1.b <= tint_mul(s.b, c.b);
			dst_s1   <= rgb_t'(dst[OUT_W-1:0]);
		end
	end

endmodule

>>> sv/tapb_weight.sv
// ----------------------------------------------------------------------------
// tapb_weight
// Second pipeline stage: forms the blend weight from the tinted alpha and
// multiplies source and destination channels by their weights.
// ----------------------------------------------------------------------------
module tapb_weight import tapb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld_in,
	output logic   rdy_in,
	input  argb_t  src,
	input  rgb_t   dst,
	output logic   vld_s2,
	input  logic   rdy_out,
	output prods_t prods_s2,
	output weight_t wgt_s2
);

	weight_t wgt;
	weight_t inv;
	logic [2:0][CH_W-1:0] sc;
	logic [2:0][CH_W-1:0] dc;

	// Alpha values of one half and above are bumped so that opaque maps to 256.
	assign wgt = {1'b0, src.a} + {{CH_W{1'b0}}, (src.a >= ALPHA_HALF)};
	assign inv = WEIGHT_FULL - wgt;
	assign sc = {src.r, src.g, src.b};
	assign dc = {dst.r, dst.g, dst.b};
	assign rdy_in = !vld_s2 || rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_in) begin
			vld_s2 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_in && vld_in) begin
			for (int i = 0; i < 3; i++) begin
				prods_s2.src[i] <= PROD_W'({{CH_W{1'b0}}, sc[i]} * {{(CH_W-1){1'b0}}, wgt});
				prods_s2.dst[i] <= PROD_W'({{CH_W{1'b0}}, dc[i]} * {{(CH_W-1){1'b0}}, inv});
			end
			wgt_s2 <= wgt;
		end
	end

endmodule

>>> sv/tapb_mix.sv
// ----------------------------------------------------------------------------
// tapb_mix
// Third pipeline stage: adds the weighted products, drops the fraction and
// holds the blended word for the output.
// ----------------------------------------------------------------------------
module tapb_mix import tapb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld_in,
	output logic   rdy_in,
	input  prods_t prods,
	output logic   vld_s3,
	input  logic   rdy_out,
	output rgb_t   pix_s3
);

	logic [2:0][PROD_W:0] sum;
	logic [2:0][CH_W-1:0] ch;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = {1'b0, prods.src[i]} + {1'b0, prods.dst[i]};
			ch[i]  = sum[i][PROD_W-1:CH_W];
		end
	end

	assign rdy_in = !vld_s3 || rdy_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_in) begin
			vld_s3 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_in && vld_in) begin
			pix_s3 <= rgb_t'(ch);
		end
	end

endmodule

>>> sv/tinted_alpha_blend_pixel_top.sv
// ----------------------------------------------------------------------------
// tinted_alpha_blend_pixel_top
// Tints a source ARGB8888 pixel and alpha blends it over a destination pixel.
// ----------------------------------------------------------------------------
// The block takes one source/destination word per clock unless it is stalled
// and returns one RGB888 word per accepted word: one stage tints the source
// channels, one forms the blend weight and the six channel products, and one
// adds the products and holds the result for the output. Each stage holds
// its word while the stage after it is full, so a stalled output backs up
// the pipeline without losing words and the input keeps taking words as long
// as a stage is free. The tint register is loaded by cfg_wr_en and should
// only change while no word is in flight; it resets to all ones.
module tinted_alpha_blend_pixel_top import tapb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [PIX_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] source_pixel,
	input  logic [PIX_W-1:0] dest_pixel,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] blended_pixel
);

	logic [PIX_W-1:0] tint_color_q;
	logic    vld_s1;
	logic    vld_s2;
	logic    rdy_s2;
	logic    rdy_s3;
	argb_t   src_s1;
	rgb_t    dst_s1;
	prods_t  prods_s2;
	weight_t wgt_s2;
	rgb_t    pix_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_color_q <= TINT_RESET;
		end else if (cfg_wr_en) begin
			tint_color_q <= cfg_wr_data;
		end
	end

	tapb_tint u_tint (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (in_valid),
		.rdy_in  (in_ready),
		.src     (source_pixel),
		.dst     (dest_pixel),
		.tint    (tint_color_q),
		.vld_s1  (vld_s1),
		.rdy_out (rdy_s2),
		.src_s1  (src_s1),
		.dst_s1  (dst_s1)
	);

	tapb_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s1),
		.rdy_in   (rdy_s2),
		.src      (src_s1),
		.dst      (dst_s1),
		.vld_s2   (vld_s2),
		.rdy_out  (rdy_s3),
		.prods_s2 (prods_s2),
		.wgt_s2   (wgt_s2)
	);

	tapb_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s2),
		.rdy_in  (rdy_s3),
		.prods   (prods_s2),
		.vld_s3  (out_valid),
		.rdy_out (out_ready),
		.pix_s3  (pix_s3)
	);

	assign blended_pixel = pix_s3;

`ifndef SYNTHESIS
	// The input can only be blocked when every stage is full and the output stalls.
	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && vld_s2 && vld_s1 && !out_ready))
		else $error("input blocked while a stage is free");

	// A held word in the first stage is not dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !rdy_s2 |=> vld_s1)
		else $error("first stage word lost during stall");

	// A held word in the second stage is not dropped and keeps its weight.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !rdy_s3 |=> vld_s2 && $stable(wgt_s2))
		else $error("second stage word changed during stall");

	// A full weight leaves nothing of the destination.
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (wgt_s2 == WEIGHT_FULL) |-> (prods_s2.dst == '0))
		else $error("destination leaks through an opaque source");
`endif

endmodule

>>> sim/tinted_alpha_blend_pixel_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tinted_alpha_blend_pixel_top_tb
// Self-checking bench for the tinted alpha blend pixel pipeline.
// ----------------------------------------------------------------------------
// Source and destination words are pushed through the valid/ready input while
// the output side takes results with random stalls. Every accepted word is
// turned into an expected RGB888 value by a local model of the tint and blend
// math, using the tint value last written, and each output word is compared
// in order against it. Tests cover corner pixels, tint extremes, a long output
// hold that fills the pipeline, and long random runs under several tints.
// ----------------------------------------------------------------------------
module tinted_alpha_blend_pixel_top_tb;
	import tapb_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 60;
	localparam int MAX_REPORTS   = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 300;

	typedef struct {
		logic [PIX_W-1:0] src;
		logic [PIX_W-1:0] dst;
		rgb_t             pix;
	} blend_job_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [PIX_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [PIX_W-1:0] source_pixel = '0;
	logic [PIX_W-1:0] dest_pixel = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [OUT_W-1:0] blended_pixel;

	blend_job_t       pending_pixels[$];
	logic [PIX_W-1:0] tint_now = TINT_RESET;
	bit               gaps_on = 1'b1;
	int               output_hold_cycles = 0;
	int               fault_count = 0;
	int               cycle_count = 0;

	tinted_alpha_blend_pixel_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_pixel  (source_pixel),
		.dest_pixel    (dest_pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blended_pixel (blended_pixel)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// Scale one channel by tint channel plus one, keep the upper byte.
	function automatic chan_t tint_scale(input chan_t s, input chan_t c);
		logic [PROD_W:0] p;
		p = (PROD_W+1)'(s) * ((PROD_W+1)'(c) + (PROD_W+1)'(1));
		return p[PROD_W-1:CH_W];
	endfunction

	function automatic chan_t mix_channel(input chan_t s, input chan_t d, input weight_t w);
		logic [PROD_W+1:0] acc;
		acc = (PROD_W+2)'(s) * (PROD_W+2)'(w)
			+ (PROD_W+2)'(d) * ((PROD_W+2)'(WEIGHT_FULL) - (PROD_W+2)'(w));
		return acc[PROD_W-1:CH_W];
	endfunction

	function automatic rgb_t blend_expect(input logic [PIX_W-1:0] src,
			input logic [PIX_W-1:0] dst, input logic [PIX_W-1:0] tint);
		argb_t   s;
		argb_t   d;
		argb_t   t;
		argb_t   m;
		weight_t w;
		rgb_t    res;
		s = src;
		d = dst;
		t = tint;
		m.a = tint_scale(s.a, t.a);
		m.r = tint_scale(s.r, t.r);
		m.g = tint_scale(s.g, t.g);
		m.b = tint_scale(s.b, t.b);
		// Alpha at or above one half is bumped so that full alpha weighs 256.
		w = {1'b0, m.a};
		if (m.a >= ALPHA_HALF) begin
			w = w + weight_t'(1);
		end
		res.r = mix_channel(m.r, d.r, w);
		res.g = mix_channel(m.g, d.g, w);
		res.b = mix_channel(m.b, d.b, w);
		return res;
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	always @(posedge clk) begin : scoreboard
		blend_job_t job;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				job.src = source_pixel;
				job.dst = dest_pixel;
				job.pix = blend_expect(source_pixel, dest_pixel, tint_now);
				pending_pixels.push_back(job);
			end
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					note_fault($sformatf("unexpected output word %06h", blended_pixel));
				end else begin
					job = pending_pixels.pop_front();
					if (blended_pixel !== job.pix) begin
						note_fault($sformatf(
							"mismatch src %08h dst %08h: expected %06h, got %06h",
							job.src, job.dst, job.pix, blended_pixel));
					end
				end
			end
		end
	end

	// Output side: a random stall before each word, or a long hold on request.
	initial begin : receiver
		int n;
		forever begin
			if (output_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (output_hold_cycles) @(posedge clk);
				output_hold_cycles = 0;
			end
			n = gaps_on ? $urandom_range(0, 5) : 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Valid is only dropped at the start of a gap, so back-to-back words keep it high.
	task automatic send_pixel(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
		int gap;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		source_pixel <= src;
		dest_pixel   <= dst;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tint(input logic [PIX_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tint_now = value;
	endtask

	// Random source word with the alpha often pushed to its edges.
	function automatic logic [PIX_W-1:0] draw_source();
		logic [PIX_W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 7))
			0: v[31:24] = 8'h00;
			1: v[31:24] = 8'hFF;
			2: v[31:24] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_directed_pixels();
		// Reset tint is full, so every channel passes through untouched.
		send_pixel(32'h0000_0000, 32'h0000_0000);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
		send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'hFF12_3456, 32'h00AB_CDEF);
		send_pixel(32'h7FFF_0080, 32'hFF00_FF7F);
		send_pixel(32'h80FF_0080, 32'h0000_FF7F);
		send_pixel(32'h8180_40C0, 32'hAA55_AA55);
		send_pixel(32'h0112_3456, 32'h7FFE_DCBA);
		send_pixel(32'hFE01_80FF, 32'h8080_8080);
		drain_pipeline();
	endtask

	task automatic test_tint_extremes();
		write_tint(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF, 32'h0012_3456);
		send_pixel(32'h80FF_8001, 32'hFFFF_FFFF);
		drain_pipeline();
		write_tint(32'hFF00_FF00);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
		send_pixel(32'hFF80_7F01, 32'hFFFF_FFFF);
		drain_pipeline();
		write_tint(32'h7F80_FE01);
		send_pixel(32'hFFFF_FFFF, 32'h00A5_5A3C);
		send_pixel(32'hFFFF_FFFF, 32'hFF00_0000);
		drain_pipeline();
		write_tint(32'h80FF_FFFF);
		send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
		send_pixel(32'hFF40_80C0, 32'h00C0_8040);
		drain_pipeline();
	endtask

	// The output holds for a long stretch while input words keep coming.
	task automatic test_backpressure();
		int i;
		write_tint(32'hFFFF_FFFF);
		gaps_on = 1'b0;
		output_hold_cycles = HOLD_CYCLES;
		for (i = 0; i < 30; i++) begin
			send_pixel(draw_source(), $urandom);
		end
		drain_pipeline();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_blends();
		int               p;
		int               i;
		logic [PIX_W-1:0] tint;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: tint = TINT_RESET;
				1: tint = 32'h0000_0000;
				2: tint = {8'hFF, 24'($urandom)};
				default: tint = $urandom;
			endcase
			write_tint(tint);
			gaps_on = (p != 3);
			for (i = 0; i < PHASE_WORDS; i++) begin
				send_pixel(draw_source(), $urandom);
			end
			drain_pipeline();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		test_directed_pixels();
		test_tint_extremes();
		test_backpressure();
		test_random_blends();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
